>>> sv/dtfb_pkg.sv
// Shared types and constants for the depth-tested frame buffer.
`timescale 1ns / 1ps
`default_nettype none

package dtfb_pkg;

  localparam int DIM_W   = 7;   // active_width / active_height registers
  localparam int COORD_W = 6;   // x_coord / y_coord
  localparam int CHAN_W  = 8;
  localparam int COL_W   = 3 * CHAN_W;
  localparam int DEP_W   = 16;
  localparam int MODE_W  = 3;
  localparam int CFG_IDX_W = 1;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  localparam logic [DEP_W-1:0] DEPTH_FAR = '1;
  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_READ    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CLR_COL = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CLR_DEP = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FLIP_H  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_FLIP_V  = 3'd5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {COL_ITEM, COL_ZERO, COL_RDA, COL_RDB} col_src_t;
  typedef enum logic [1:0] {WA_A, WA_B, WA_INIT} wr_sel_t;
  typedef enum logic [1:0] {RES_NONE, RES_OOR, RES_READ, RES_WRITE} res_kind_t;

  typedef struct packed {
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] row;
  } pos_t;

  typedef struct packed {
    logic      item_load;
    logic      rd_en;
    logic      col_we;
    logic      dep_we;
    col_src_t  col_src;
    logic      dep_far;
    wr_sel_t   wr_sel;
    logic      res_load;
    res_kind_t res_kind;
  } cmd_t;

  typedef struct packed {
    logic init_last;
    logic depth_pass;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

>>> sv/depth_tested_framebuffer_top.sv
// Top level of the depth-tested colour and depth frame buffer.
`timescale 1ns / 1ps
`default_nettype none

// Channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------------
// config   | cfg_we               | cfg_index (0 width, 1 height), cfg_data[6:0]
// input    | in_valid / in_ready  | mode, x_coord, y_coord, in_red/green/blue, frag_depth
// output   | out_valid / out_ready| out_red/green/blue, out_depth, depth_pass, out_of_range
//
// Steps per transaction, accept to result in the output register:
//   read / write fragment in the active area: store read, compare/write, load;
//   out-of-range access or unused mode: load only;
//   clear colour / clear depth: one store entry written per cycle, then load;
//   flip: per swapped pair, read both pixels, write each back on the
//   single store write port; then load.
// Reset runs a clearing pass over all MAX_WIDTH*MAX_HEIGHT entries
//   with in_ready low; register writes are taken throughout.
// The output register lets a new transaction start while a result waits; the
//   sequencer only holds in its last step when that register is still full.

module depth_tested_framebuffer_top
  import dtfb_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // register port
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data,
  // input transactions
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [MODE_W-1:0]    mode,
  input  wire logic [COORD_W-1:0]   x_coord,
  input  wire logic [COORD_W-1:0]   y_coord,
  input  wire logic [CHAN_W-1:0]    in_red,
  input  wire logic [CHAN_W-1:0]    in_green,
  input  wire logic [CHAN_W-1:0]    in_blue,
  input  wire logic [DEP_W-1:0]     frag_depth,
  // result transactions
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [CHAN_W-1:0]         out_red,
  output logic [CHAN_W-1:0]         out_green,
  output logic [CHAN_W-1:0]         out_blue,
  output logic [DEP_W-1:0]          out_depth,
  output logic                      depth_pass,
  output logic                      out_of_range
);

  cmd_t    cmd;
  status_t st;
  pos_t    pos_a;
  pos_t    pos_b;

  // Sequencer: mode decode, range check, sweep counters, active size registers
  dtfb_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .st        (st),
    .cmd       (cmd),
    .pos_a     (pos_a),
    .pos_b     (pos_b)
  );

  // Stores, depth compare and the result register
  dtfb_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .pos_a        (pos_a),
    .pos_b        (pos_b),
    .st           (st),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .frag_depth   (frag_depth),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_depth    (out_depth),
    .depth_pass   (depth_pass),
    .out_of_range (out_of_range)
  );

endmodule

`default_nettype wire

>>> sv/dtfb_ctrl.sv
// Sequencer for the depth-tested frame buffer: modes, sweeps and register file.
`timescale 1ns / 1ps
`default_nettype none

module dtfb_ctrl
  import dtfb_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [MODE_W-1:0]    mode,
  input  wire logic [COORD_W-1:0]   x_coord,
  input  wire logic [COORD_W-1:0]   y_coord,
  input  wire status_t              st,
  output cmd_t                      cmd,
  output pos_t                      pos_a,
  output pos_t                      pos_b
);

  localparam int DIM_MAX = (1 << DIM_W) - 1;
  localparam int W_CAP   = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
  localparam int H_CAP   = (MAX_HEIGHT < DIM_MAX) ? MAX_HEIGHT : DIM_MAX;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_PIX_RD, ST_PIX_CMP, ST_FILL,
    ST_SWAP_RD, ST_SWAP_WA, ST_SWAP_WB, ST_FINISH
  } state_t;

  state_t           state;
  logic [DIM_W-1:0] act_w;
  logic [DIM_W-1:0] act_h;
  logic [MODE_W-1:0] mode_q;
  res_kind_t        kind_q;
  logic [DIM_W-1:0] col_i;
  logic [DIM_W-1:0] row_j;

  logic [DIM_W-1:0] w_eff, h_eff, half_w, half_h, col_end, row_end;
  logic [DIM_W-1:0] col_i_next, row_j_next;
  logic             sweep_last, in_area, is_flip_h, is_flip_v;

  // Clamp the active size into 1..MAX
  always_comb begin
    if (act_w == '0) w_eff = DIM_W'(1);
    else if (act_w > DIM_W'(W_CAP)) w_eff = DIM_W'(W_CAP);
    else w_eff = act_w;
    if (act_h == '0) h_eff = DIM_W'(1);
    else if (act_h > DIM_W'(H_CAP)) h_eff = DIM_W'(H_CAP);
    else h_eff = act_h;
  end

  assign half_w    = w_eff >> 1;
  assign half_h    = h_eff >> 1;
  assign is_flip_h = (mode_q == MODE_FLIP_H);
  assign is_flip_v = (mode_q == MODE_FLIP_V);
  assign col_end   = is_flip_h ? half_w - DIM_W'(1) : w_eff - DIM_W'(1);
  assign row_end   = is_flip_v ? half_h - DIM_W'(1) : h_eff - DIM_W'(1);

  assign sweep_last = (col_i == col_end) && (row_j == row_end);
  assign col_i_next = (col_i == col_end) ? '0 : col_i + DIM_W'(1);
  assign row_j_next = (col_i == col_end) ? row_j + DIM_W'(1) : row_j;

  assign in_area = (DIM_W'(x_coord) < w_eff) && (DIM_W'(y_coord) < h_eff);

  assign in_ready = (state == ST_IDLE);

  assign pos_a.col = col_i;
  assign pos_a.row = row_j;
  assign pos_b.col = is_flip_h ? w_eff - DIM_W'(1) - col_i : col_i;
  assign pos_b.row = is_flip_v ? h_eff - DIM_W'(1) - row_j : row_j;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_INIT;
      act_w  <= DIM_RESET;
      act_h  <= DIM_RESET;
      kind_q <= RES_NONE;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WIDTH:  act_w <= cfg_data;
          CFG_HEIGHT: act_h <= cfg_data;
          default:    act_w <= act_w;
        endcase
      end
      unique case (state)
        ST_INIT: begin
          if (st.init_last) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid) begin
            mode_q <= mode;
            if (mode == MODE_WRITE || mode == MODE_READ) begin
              if (in_area) begin
                col_i  <= DIM_W'(x_coord);
                row_j  <= DIM_W'(y_coord);
                kind_q <= (mode == MODE_WRITE) ? RES_WRITE : RES_READ;
                state  <= ST_PIX_RD;
              end else begin
                kind_q <= RES_OOR;
                state  <= ST_FINISH;
              end
            end else begin
              col_i  <= '0;
              row_j  <= '0;
              kind_q <= RES_NONE;
              priority if (mode == MODE_CLR_COL || mode == MODE_CLR_DEP) begin
                state <= ST_FILL;
              end else if (mode == MODE_FLIP_H) begin
                state <= (half_w == '0) ? ST_FINISH : ST_SWAP_RD;
              end else if (mode == MODE_FLIP_V) begin
                state <= (half_h == '0) ? ST_FINISH : ST_SWAP_RD;
              end else begin
                state <= ST_FINISH;
              end
            end
          end
        end
        ST_PIX_RD:  state <= ST_PIX_CMP;
        ST_PIX_CMP: state <= ST_FINISH;
        ST_FILL: begin
          col_i <= col_i_next;
          row_j <= row_j_next;
          if (sweep_last) state <= ST_FINISH;
        end
        ST_SWAP_RD: state <= ST_SWAP_WA;
        ST_SWAP_WA: state <= ST_SWAP_WB;
        ST_SWAP_WB: begin
          col_i <= col_i_next;
          row_j <= row_j_next;
          state <= sweep_last ? ST_FINISH : ST_SWAP_RD;
        end
        ST_FINISH: begin
          if (st.out_free) state <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd.item_load = 1'b0;
    cmd.rd_en     = 1'b0;
    cmd.col_we    = 1'b0;
    cmd.dep_we    = 1'b0;
    cmd.col_src   = COL_ITEM;
    cmd.dep_far   = 1'b0;
    cmd.wr_sel    = WA_A;
    cmd.res_load  = 1'b0;
    cmd.res_kind  = kind_q;
    unique case (state)
      ST_INIT: begin
        cmd.col_we  = 1'b1;
        cmd.dep_we  = 1'b1;
        cmd.col_src = COL_ZERO;
        cmd.dep_far = 1'b1;
        cmd.wr_sel  = WA_INIT;
      end
      ST_IDLE:   cmd.item_load = in_valid;
      ST_PIX_RD: cmd.rd_en = 1'b1;
      ST_PIX_CMP: begin
        cmd.col_we = (mode_q == MODE_WRITE) && st.depth_pass;
        cmd.dep_we = (mode_q == MODE_WRITE) && st.depth_pass;
      end
      ST_FILL: begin
        cmd.col_we  = (mode_q == MODE_CLR_COL);
        cmd.dep_we  = (mode_q == MODE_CLR_DEP);
        cmd.dep_far = 1'b1;
      end
      ST_SWAP_RD: cmd.rd_en = 1'b1;
      ST_SWAP_WA: begin
        cmd.col_we  = 1'b1;
        cmd.col_src = COL_RDB;
      end
      ST_SWAP_WB: begin
        cmd.col_we  = 1'b1;
        cmd.col_src = COL_RDA;
        cmd.wr_sel  = WA_B;
      end
      ST_FINISH: cmd.res_load = st.out_free;
    endcase
  end

  // One transaction at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("dtfb_ctrl: input taken twice in a row");

  // Read data must be consumed before the next read overwrites it
  a_rd_spacing: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |=> !cmd.rd_en)
    else $error("dtfb_ctrl: back-to-back store reads");

  a_sweep_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL || state == ST_SWAP_WB) |-> (col_i <= col_end && row_j <= row_end))
    else $error("dtfb_ctrl: sweep counter past active area");

endmodule

`default_nettype wire

>>> sv/dtfb_datapath.sv
// Colour and depth stores, depth compare and result register.
`timescale 1ns / 1ps
`default_nettype none

module dtfb_datapath
  import dtfb_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  input  wire pos_t              pos_a,
  input  wire pos_t              pos_b,
  output status_t                st,
  input  wire logic [CHAN_W-1:0] in_red,
  input  wire logic [CHAN_W-1:0] in_green,
  input  wire logic [CHAN_W-1:0] in_blue,
  input  wire logic [DEP_W-1:0]  frag_depth,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [CHAN_W-1:0]      out_red,
  output logic [CHAN_W-1:0]      out_green,
  output logic [CHAN_W-1:0]      out_blue,
  output logic [DEP_W-1:0]       out_depth,
  output logic                   depth_pass,
  output logic                   out_of_range
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  logic [COL_W-1:0] colour_mem [DEPTH];
  logic [DEP_W-1:0] depth_mem  [DEPTH];

  logic [COL_W-1:0] frag_colour;
  logic [DEP_W-1:0] frag_depth_q;
  logic [COL_W-1:0] rd_col_a, rd_col_b;
  logic [DEP_W-1:0] rd_dep;
  logic [AW-1:0]    init_addr;
  logic [AW-1:0]    addr_a, addr_b, wr_addr;
  logic [COL_W-1:0] col_wdata;
  logic [DEP_W-1:0] dep_wdata;

  // Pixel (x, y) sits at y * MAX_WIDTH + x
  assign addr_a = AW'(pos_a.row) * AW'(MAX_WIDTH) + AW'(pos_a.col);
  assign addr_b = AW'(pos_b.row) * AW'(MAX_WIDTH) + AW'(pos_b.col);

  always_comb begin
    unique case (cmd.wr_sel)
      WA_A:    wr_addr = addr_a;
      WA_B:    wr_addr = addr_b;
      WA_INIT: wr_addr = init_addr;
      default: wr_addr = addr_a;
    endcase
    unique case (cmd.col_src)
      COL_ITEM: col_wdata = frag_colour;
      COL_ZERO: col_wdata = '0;
      COL_RDA:  col_wdata = rd_col_a;
      COL_RDB:  col_wdata = rd_col_b;
    endcase
  end

  assign dep_wdata = cmd.dep_far ? DEPTH_FAR : frag_depth_q;

  assign st.init_last  = (init_addr == AW'(DEPTH - 1));
  assign st.depth_pass = (frag_depth_q < rd_dep);
  assign st.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      frag_colour  <= {in_red, in_green, in_blue};
      frag_depth_q <= frag_depth;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.col_we) colour_mem[wr_addr] <= col_wdata;
    if (cmd.dep_we) depth_mem[wr_addr] <= dep_wdata;
    if (cmd.rd_en) begin
      rd_col_a <= colour_mem[addr_a];
      rd_col_b <= colour_mem[addr_b];
      rd_dep   <= depth_mem[addr_a];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_addr <= '0;
    end else if (cmd.wr_sel == WA_INIT && cmd.col_we) begin
      init_addr <= init_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_red      <= (cmd.res_kind == RES_READ) ? rd_col_a[3*CHAN_W-1:2*CHAN_W] : '0;
      out_green    <= (cmd.res_kind == RES_READ) ? rd_col_a[2*CHAN_W-1:CHAN_W] : '0;
      out_blue     <= (cmd.res_kind == RES_READ) ? rd_col_a[CHAN_W-1:0] : '0;
      out_depth    <= (cmd.res_kind == RES_READ) ? rd_dep : '0;
      depth_pass   <= (cmd.res_kind == RES_WRITE) && st.depth_pass;
      out_of_range <= (cmd.res_kind == RES_OOR);
    end
  end

  // A fragment lands only when it beat the stored depth
  a_frag_passes: assert property (@(posedge clk) disable iff (rst)
    (cmd.dep_we && !cmd.dep_far) |-> (frag_depth_q < rd_dep))
    else $error("dtfb_datapath: fragment stored without passing depth test");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!out_valid || out_ready))
    else $error("dtfb_datapath: result register overwritten");

endmodule

`default_nettype wire

>>> verif/depth_tested_framebuffer_top_tb.sv
// Self-checking testbench for the depth-tested colour and depth frame buffer.
`timescale 1ns / 1ps

// Stimulus: a directed opening at the reset size and at an odd 5x3 area, then
// ten random phases, each at its own active size (zero and oversize register
// values among them). Between phases the bench waits until every predicted
// result has come back before it rewrites the size registers.
//
// Prediction: a behavioral frame store (colour + depth arrays at full size)
// is updated at every accepted input transaction. The result that it gives is
// queued, and the monitor checks each output transaction against the oldest
// entry of that queue, field by field.
//
// Flow control: both sides idle at random, except for one phase with no idling
// at all. In one phase the receiver holds off for a long stretch so that the
// block backs up and drops in_ready.

module depth_tested_framebuffer_top_tb;
  import dtfb_pkg::*;

  localparam int FB_W = DEF_MAX_WIDTH;
  localparam int FB_H = DEF_MAX_HEIGHT;
  localparam int IDLE_PCT = 38;
  localparam int HOLDOFF_CYCLES = 300;
  // The limit is several times the longest quiet stretch, that of a full-size
  // flip, which is longer than the reset clearing pass.
  localparam int QUIET_LIMIT = 40000;
  localparam int NUM_PHASES = 10;
  localparam int OPS_PER_PHASE = 153;

  // Modes 6 and 7 have no function; the block must answer with all zeros.
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [DEP_W-1:0]   depth;
  } pixel_op_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [DEP_W-1:0]  depth;
    logic              pass;
    logic              oor;
  } pixel_resp_t;

  // Random phases: raw register values, and percent of walking ops
  // (clears and flips). Full-size phases get few walking ops, as each one
  // sweeps the whole active area.
  int phase_w[NUM_PHASES]     = '{0, 127, 7, 2, 16, 64, 1, 33, 4, 9};
  int phase_h[NUM_PHASES]     = '{0, 90, 5, 2, 16, 1, 127, 3, 4, 8};
  int phase_heavy[NUM_PHASES] = '{10, 1, 8, 10, 6, 8, 8, 6, 10, 8};

  // DUT ports
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WIDTH;
  logic [DIM_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [MODE_W-1:0]    mode = MODE_WRITE;
  logic [COORD_W-1:0]   x_coord = '0;
  logic [COORD_W-1:0]   y_coord = '0;
  logic [CHAN_W-1:0]    in_red = '0;
  logic [CHAN_W-1:0]    in_green = '0;
  logic [CHAN_W-1:0]    in_blue = '0;
  logic [DEP_W-1:0]     frag_depth = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CHAN_W-1:0]    out_red;
  logic [CHAN_W-1:0]    out_green;
  logic [CHAN_W-1:0]    out_blue;
  logic [DEP_W-1:0]     out_depth;
  logic                 depth_pass;
  logic                 out_of_range;

  // Predicted frame store and size registers
  logic [COL_W-1:0] colour_mem [FB_W*FB_H];
  logic [DEP_W-1:0] depth_mem  [FB_W*FB_H];
  logic [DIM_W-1:0] width_reg  = DIM_RESET;
  logic [DIM_W-1:0] height_reg = DIM_RESET;

  pixel_op_t   pending_ops[$];
  pixel_resp_t expected_resps[$];

  // Flow-control knobs, set by the stimulus process
  bit no_idle = 1'b0;
  bit holdoff_armed = 1'b0;

  // Bookkeeping
  int ops_pushed = 0;
  int ops_accepted = 0;
  int resps_seen = 0;
  int stored_seen = 0;
  int oor_seen = 0;
  int errors = 0;
  int sizes_tried = 0;
  int quiet_cycles = 0;
  int mode_count[8] = '{default: 0};

  depth_tested_framebuffer_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .x_coord      (x_coord),
    .y_coord      (y_coord),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .frag_depth   (frag_depth),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_depth    (out_depth),
    .depth_pass   (depth_pass),
    .out_of_range (out_of_range)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Register values of 0 act as 1, values above the store size act as the max.
  function automatic int effective_dim(logic [DIM_W-1:0] raw, int limit);
    if (raw == 0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  // Applies one transaction to the predicted frame store, returns its result.
  function automatic pixel_resp_t frame_model_apply(pixel_op_t op);
    pixel_resp_t      resp;
    int               w, h, i, j, addr, mirror;
    logic [COL_W-1:0] swap_tmp;
    w = effective_dim(width_reg, FB_W);
    h = effective_dim(height_reg, FB_H);
    resp = '0;
    case (op.mode)
      MODE_WRITE, MODE_READ: begin
        if (op.x >= w || op.y >= h) begin
          resp.oor = 1'b1;
        end else begin
          addr = op.y * FB_W + op.x;
          if (op.mode == MODE_WRITE) begin
            // strictly nearer only: equal depth loses
            if (op.depth < depth_mem[addr]) begin
              depth_mem[addr]  = op.depth;
              colour_mem[addr] = {op.red, op.green, op.blue};
              resp.pass = 1'b1;
            end
          end else begin
            {resp.red, resp.green, resp.blue} = colour_mem[addr];
            resp.depth = depth_mem[addr];
          end
        end
      end
      MODE_CLR_COL: begin
        for (j = 0; j < h; j++)
          for (i = 0; i < w; i++)
            colour_mem[j*FB_W + i] = {op.red, op.green, op.blue};
      end
      MODE_CLR_DEP: begin
        for (j = 0; j < h; j++)
          for (i = 0; i < w; i++)
            depth_mem[j*FB_W + i] = DEPTH_FAR;
      end
      MODE_FLIP_H: begin
        // colour only; middle column stays for odd widths
        for (j = 0; j < h; j++)
          for (i = 0; i < w/2; i++) begin
            addr = j*FB_W + i;
            mirror = j*FB_W + (w - 1 - i);
            swap_tmp = colour_mem[addr];
            colour_mem[addr] = colour_mem[mirror];
            colour_mem[mirror] = swap_tmp;
          end
      end
      MODE_FLIP_V: begin
        for (j = 0; j < h/2; j++)
          for (i = 0; i < w; i++) begin
            addr = j*FB_W + i;
            mirror = (h - 1 - j)*FB_W + i;
            swap_tmp = colour_mem[addr];
            colour_mem[addr] = colour_mem[mirror];
            colour_mem[mirror] = swap_tmp;
          end
      end
      default: ;
    endcase
    return resp;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch on result %0d: expected %0h, actual %0h",
               $time, name, resps_seen, want, got);
      errors++;
    end
  endtask

  task automatic queue_op(pixel_op_t op);
    pending_ops.push_back(op);
    ops_pushed++;
  endtask

  task automatic push_op(logic [MODE_W-1:0] m, int x, int y, logic [COL_W-1:0] rgb,
                         logic [DEP_W-1:0] d);
    pixel_op_t op;
    op.mode = m;
    op.x = COORD_W'(x);
    op.y = COORD_W'(y);
    {op.red, op.green, op.blue} = rgb;
    op.depth = d;
    queue_op(op);
  endtask

  // Mostly reads and writes in the active area, often hitting the pixel just
  // touched so that reads see written data; some walking ops, spare modes and
  // coordinates anywhere in the 6-bit range.
  task automatic push_random_ops(int count, int heavy_pct);
    pixel_op_t          op;
    int                 w, h, n, pick;
    logic [COORD_W-1:0] last_x, last_y;
    w = effective_dim(width_reg, FB_W);
    h = effective_dim(height_reg, FB_H);
    last_x = '0;
    last_y = '0;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < heavy_pct) begin
        case ($urandom_range(0, 3))
          0: op.mode = MODE_CLR_COL;
          1: op.mode = MODE_CLR_DEP;
          2: op.mode = MODE_FLIP_H;
          default: op.mode = MODE_FLIP_V;
        endcase
      end else if (pick < heavy_pct + 3) begin
        op.mode = $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
      end else if (pick < 60) begin
        op.mode = MODE_WRITE;
      end else begin
        op.mode = MODE_READ;
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        op.x = last_x;
        op.y = last_y;
      end else if (pick < 90) begin
        op.x = COORD_W'($urandom_range(0, w - 1));
        op.y = COORD_W'($urandom_range(0, h - 1));
      end else begin
        op.x = COORD_W'($urandom_range(0, 63));
        op.y = COORD_W'($urandom_range(0, 63));
      end
      last_x = op.x;
      last_y = op.y;
      op.red   = CHAN_W'($urandom_range(0, 255));
      op.green = CHAN_W'($urandom_range(0, 255));
      op.blue  = CHAN_W'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 8)       op.depth = '0;
      else if (pick < 16) op.depth = DEPTH_FAR;
      else                op.depth = DEP_W'($urandom_range(0, 65535));
      queue_op(op);
    end
  endtask

  // Every transaction yields exactly one result, so the block is idle once all
  // pushed ops are accepted and answered; a few spare cycles on top.
  task automatic wait_drained();
    while (ops_accepted != ops_pushed || expected_resps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_size(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= CFG_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we    <= 1'b0;
    width_reg  = w;
    height_reg = h;
    sizes_tried++;
  endtask

  // Driver: offers the next pending op; valid holds with a stable payload
  // until the transaction goes through. Prediction happens on acceptance.
  always @(posedge clk) begin : drive_ops
    pixel_op_t cur_op;
    pixel_op_t next_op;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        cur_op = {mode, x_coord, y_coord, in_red, in_green, in_blue, frag_depth};
        expected_resps.push_back(frame_model_apply(cur_op));
        mode_count[cur_op.mode]++;
        ops_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_ops.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
          next_op = pending_ops.pop_front();
          in_valid   <= 1'b1;
          mode       <= next_op.mode;
          x_coord    <= next_op.x;
          y_coord    <= next_op.y;
          in_red     <= next_op.red;
          in_green   <= next_op.green;
          in_blue    <= next_op.blue;
          frag_depth <= next_op.depth;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every result transaction and drives out_ready, including
  // the one long hold-off that backs the block up.
  always @(posedge clk) begin : check_results
    pixel_resp_t want;
    int          hold_left;
    bit          holdoff_done;
    if (rst) begin
      out_ready    <= 1'b0;
      hold_left    = 0;
      holdoff_done = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_resps.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual rgb %h %h %h",
                   $time, out_red, out_green, out_blue);
          $display("    depth %h pass %b oor %b", out_depth, depth_pass, out_of_range);
          errors++;
        end else begin
          want = expected_resps.pop_front();
          check_field("out_red", want.red, out_red);
          check_field("out_green", want.green, out_green);
          check_field("out_blue", want.blue, out_blue);
          check_field("out_depth", want.depth, out_depth);
          check_field("depth_pass", want.pass, depth_pass);
          check_field("out_of_range", want.oor, out_of_range);
        end
        resps_seen++;
        if (depth_pass) stored_seen++;
        if (out_of_range) oor_seen++;
      end
      if (holdoff_armed && !holdoff_done) begin
        hold_left    = HOLDOFF_CYCLES;
        holdoff_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || $urandom_range(0, 99) >= IDLE_PCT;
      end
    end
  end

  // Watchdog: ends the run if no transaction moves on either side for too long.
  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results still expected",
               $time, quiet_cycles, expected_resps.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int k;
    int phase;
    for (k = 0; k < FB_W*FB_H; k++) begin
      colour_mem[k] = '0;
      depth_mem[k]  = DEPTH_FAR;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset size 64x64: cleared store, depth test edges, spare modes, flip, depth clear.
    push_op(MODE_READ, 0, 0, '0, '0);
    push_op(MODE_READ, 63, 63, '0, '0);
    push_op(MODE_WRITE, 10, 20, 24'hFFFFFF, DEPTH_FAR);  // farthest never passes
    push_op(MODE_READ, 10, 20, '0, '0);
    push_op(MODE_WRITE, 63, 63, 24'hFF00FF, 16'h0000);
    push_op(MODE_WRITE, 63, 63, 24'h123456, 16'h0000);   // equal depth loses
    push_op(MODE_READ, 63, 63, '0, '0);
    push_op(MODE_WRITE, 0, 0, 24'h010203, 16'hFFFE);
    push_op(MODE_SPARE_LO, 63, 63, 24'hFFFFFF, DEPTH_FAR);
    push_op(MODE_SPARE_HI, 0, 0, '0, '0);
    push_op(MODE_FLIP_H, 0, 0, '0, '0);
    push_op(MODE_READ, 0, 63, '0, '0);
    push_op(MODE_CLR_DEP, 0, 0, '0, '0);
    push_op(MODE_READ, 0, 63, '0, '0);
    wait_drained();

    // Directed, odd 5x3 area: middle column/row stays put, bounds checks, colour clear.
    set_size(7'd5, 7'd3);
    push_op(MODE_WRITE, 4, 2, 24'hA1B2C3, 16'd100);
    push_op(MODE_WRITE, 2, 1, 24'h445566, 16'd200);
    push_op(MODE_FLIP_H, 0, 0, '0, '0);
    push_op(MODE_READ, 0, 2, '0, '0);
    push_op(MODE_READ, 2, 1, '0, '0);
    push_op(MODE_FLIP_V, 0, 0, '0, '0);
    push_op(MODE_READ, 0, 0, '0, '0);
    push_op(MODE_WRITE, 5, 0, 24'hFFFFFF, 16'h0000);     // x just past the edge
    push_op(MODE_READ, 0, 3, '0, '0);                    // y just past the edge
    push_op(MODE_CLR_COL, 0, 0, 24'hAABBCC, '0);
    push_op(MODE_READ, 1, 1, '0, '0);

    // Random phases, one active size each.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      wait_drained();
      set_size(DIM_W'(phase_w[phase]), DIM_W'(phase_h[phase]));
      no_idle = (phase == 8);
      push_random_ops(OPS_PER_PHASE, phase_heavy[phase]);
      if (phase == 4) holdoff_armed = 1'b1;
    end
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Covered %0d transactions over %0d size settings:", ops_accepted, sizes_tried);
    $display("  %0d writes (%0d stored), %0d reads, %0d out of range.",
             mode_count[MODE_WRITE], stored_seen, mode_count[MODE_READ], oor_seen);
    $display("Walking ops: %0d colour clears, %0d depth clears, %0d flips;",
             mode_count[MODE_CLR_COL], mode_count[MODE_CLR_DEP],
             mode_count[MODE_FLIP_H] + mode_count[MODE_FLIP_V]);
    $display("  %0d spare-mode items; %0d errors.",
             mode_count[MODE_SPARE_LO] + mode_count[MODE_SPARE_HI], errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
